// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; ASSERT_OFF compiles them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ETOK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ETOK_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ETOK_ASSERT(lbl, clk, rst_n, prop, msg)
`define ETOK_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/etok_pkg.sv =====
// ---------------------------------------------------------------------------
// Expression tokenizer package
// Token record, codes, queue sizing and the power-of-ten table.
// ---------------------------------------------------------------------------
package etok_pkg;

  localparam int FRAC_BITS = 32;
  localparam int MAX_FRAC_DIGITS = 18;
  localparam int QDEPTH = 8;
  localparam int QAW = 3;
  localparam int QCW = 4;
  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DCW = 7;

  localparam logic [63:0] PI_VALUE = 64'd13493037704;

  localparam logic [4:0] K_NUM   = 5'd0;
  localparam logic [4:0] K_PLUS  = 5'd1;
  localparam logic [4:0] K_MINUS = 5'd2;
  localparam logic [4:0] K_MUL   = 5'd3;
  localparam logic [4:0] K_DIV   = 5'd4;
  localparam logic [4:0] K_POW   = 5'd5;
  localparam logic [4:0] K_MOD   = 5'd6;
  localparam logic [4:0] K_COS   = 5'd7;
  localparam logic [4:0] K_SIN   = 5'd8;
  localparam logic [4:0] K_SQRT  = 5'd9;
  localparam logic [4:0] K_TAN   = 5'd10;
  localparam logic [4:0] K_ASIN  = 5'd11;
  localparam logic [4:0] K_ACOS  = 5'd12;
  localparam logic [4:0] K_ATAN  = 5'd13;
  localparam logic [4:0] K_LN    = 5'd14;
  localparam logic [4:0] K_LOG   = 5'd15;
  localparam logic [4:0] K_OPEN  = 5'd16;
  localparam logic [4:0] K_CLOSE = 5'd17;

  localparam logic [2:0] P_NUM  = 3'd0;
  localparam logic [2:0] P_ADD  = 3'd1;
  localparam logic [2:0] P_MUL  = 3'd2;
  localparam logic [2:0] P_POW  = 3'd3;
  localparam logic [2:0] P_FUNC = 3'd4;
  localparam logic [2:0] P_BRKT = 3'd5;

  typedef enum logic [1:0] {FR_RUN, FR_FLUSH, FR_FINAL, FR_DONE} fr_state_e;
  typedef enum logic {BK_IDLE, BK_DIV} bk_state_e;

  // raw set: value holds the decimal mantissa, fcnt its fraction digits
  typedef struct packed {
    logic [4:0]  kind;
    logic [2:0]  prio;
    logic [63:0] value;
    logic        raw;
    logic [4:0]  fcnt;
    logic        eor;
  } tok_t;

  typedef struct packed {
    logic [1:0] n;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  function automatic tok_t mk_tok(logic [4:0] kind, logic [2:0] prio, logic [63:0] value);
    tok_t t;
    t = '0;
    t.kind = kind;
    t.prio = prio;
    t.value = value;
    return t;
  endfunction

  function automatic tok_t mk_raw(logic [63:0] mant, logic [4:0] fcnt);
    tok_t t;
    t = '0;
    t.kind = K_NUM;
    t.prio = P_NUM;
    t.value = mant;
    t.raw = 1'b1;
    t.fcnt = fcnt;
    return t;
  endfunction

  function automatic logic [63:0] pow10(logic [4:0] c);
    logic [63:0] p;
    case (c)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      default: p = 64'd1000000000000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/etok_ifs.sv =====
// ---------------------------------------------------------------------------
// Expression tokenizer channels
// Character, token and configuration valid/ready channels.
// ---------------------------------------------------------------------------
interface etok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

interface etok_tok_if;
  logic               valid;
  logic               ready;
  logic [4:0]         kind;
  logic [2:0]         priority_res;
  logic signed [63:0] value;
  logic               end_of_run;
  modport source (output valid, kind, priority_res, value, end_of_run, input ready);
  modport sink (input valid, kind, priority_res, value, end_of_run, output ready);
endinterface

interface etok_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hw/rtl/expression_tokenizer.sv =====
// ---------------------------------------------------------------------------
// Expression tokenizer
// Streams characters in, tokens (kind, priority, Q32.32 value) out.
// ---------------------------------------------------------------------------
// Use: char_i takes one character per beat, with last on the final one.
// tok_o gives one token per beat; end_of_run marks the final token of an
// expression. cfg_i writes x_value (always ready); the user must write it
// only while idle, which the block does not enforce. Throughput: one
// character per cycle while the run continues and two queue entries are
// free, also for a character that makes two tokens; a last character
// stalls input while the window drains and the final token is tagged.
// Path: a character is classified as it leaves the window; an operator
// token then passes the token queue and the output register to tok_o.
// A number with fraction digits goes through the divider (one quotient
// bit per cycle, 64 integer and 32 fraction bits); integers skip it. The
// divider serializes numbers; the eight-entry token queue lets the front
// keep accepting until fewer than two entries are free.
// Reset: all run state and x_value clear; no outputs are valid.
// Stall: tok_o holds its beat while ready is low; the queue fills and then
// char_i drops ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module expression_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  etok_char_if.sink   char_i,
  etok_cfg_if.sink    cfg_i,
  etok_tok_if.source  tok_o
);
  import etok_pkg::*;

  push_t       push;
  logic        pop, q_valid;
  tok_t        head;
  logic [3:0]  free;

  // front: window, classification, number accumulation
  etok_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_i),
    .cfg_i  (cfg_i),
    .free_i (free),
    .push_o (push)
  );

  // queue decouples classification from conversion
  etok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head),
    .free_o  (free)
  );

  // back: number conversion and the output register
  etok_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .tok_o   (tok_o)
  );

  // front never writes more tokens than the queue has room for
  `ETOK_ASSERT(a_push_fits, clk_i, rst_ni, 4'(push.n) <= free, "queue overflow")
  // back never reads an empty queue
  `ETOK_NEVER(a_pop_empty, clk_i, rst_ni, pop && !q_valid, "queue underflow")
  // input is held off while the queue cannot take a double emission
  `ETOK_NEVER(a_ready_room, clk_i, rst_ni, char_i.ready && free < 4'd2, "ready without room")

endmodule

// ===== hw/rtl/etok_front.sv =====
// ---------------------------------------------------------------------------
// Tokenizer front end
// Lookahead window, character classification and number accumulation.
// ---------------------------------------------------------------------------
module etok_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  etok_char_if.sink          char_i,
  etok_cfg_if.sink           cfg_i,
  input  logic [3:0]         free_i,
  output etok_pkg::push_t    push_o
);
  import etok_pkg::*;

  fr_state_e   st_q, st_d;
  logic [7:0]  w_q [4];
  logic [7:0]  w_d [4];
  logic [2:0]  n_q, n_d;
  logic [7:0]  prev_q, prev_d;
  logic        any_q, any_d, innum_q, innum_d, seen_q, seen_d;
  logic [63:0] mant_q, mant_d;
  logic [4:0]  fcnt_q, fcnt_d;
  logic [1:0]  skip_q, skip_d;
  tok_t        hold_q, hold_d;
  logic        hv_q, hv_d;
  logic [63:0] x_q;

  logic        go, acc, dec_en;
  logic [7:0]  c, a, b, d;
  logic        digit, mark, fits;
  logic [3:0]  dig;
  logic [67:0] m10;
  logic        pre_v, main_v;
  tok_t        pre_t, main_t, n0, n1;
  logic [1:0]  nn;

  assign go = free_i >= QCW'(2);
  assign char_i.ready = (st_q == FR_RUN) && go;
  assign acc = char_i.valid && char_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) x_q <= '0;
    else if (cfg_i.valid) x_q <= cfg_i.data;
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      FR_RUN:   if (acc && char_i.last) st_d = FR_FLUSH;
      FR_FLUSH: if (go && n_q == 3'd1) st_d = FR_FINAL;
      FR_FINAL: if (go) st_d = FR_DONE;
      FR_DONE:  if (go) st_d = FR_RUN;
      default:  st_d = FR_RUN;
    endcase
  end

  assign dec_en = (acc && !char_i.last && n_q == 3'd3) || (st_q == FR_FLUSH && go);

  always_comb begin
    c = w_q[0];
    a = w_q[1];
    b = w_q[2];
    d = (st_q == FR_FLUSH) ? w_q[3] : char_i.ch;
  end

  assign digit = c >= "0" && c <= "9";
  assign mark = c == "." || c == ",";
  assign dig = 4'(c - "0");
  assign m10 = {1'b0, mant_q, 3'b0} + {3'b0, mant_q, 1'b0} + {64'b0, dig};
  assign fits = m10[67:64] == 4'd0;

  // classification of the character at the head of the window
  always_comb begin
    prev_d = prev_q;
    innum_d = innum_q;
    seen_d = seen_q;
    mant_d = mant_q;
    fcnt_d = fcnt_q;
    skip_d = skip_q;
    pre_v = 1'b0;
    main_v = 1'b0;
    pre_t = '0;
    main_t = '0;
    if (dec_en) begin
      prev_d = c;
      if (skip_q != 2'd0) begin
        skip_d = skip_q - 2'd1;
      end else if (innum_q && (digit || mark)) begin
        if (mark) seen_d = 1'b1;
        else if (seen_q) begin
          if (fcnt_q < 5'(MAX_FRAC_DIGITS) && fits) begin
            mant_d = m10[63:0];
            fcnt_d = fcnt_q + 5'd1;
          end
        end else mant_d = fits ? m10[63:0] : '1;
      end else begin
        if (innum_q) begin
          pre_v = 1'b1;
          pre_t = mk_raw(mant_q, fcnt_q);
          innum_d = 1'b0;
        end
        if (digit) begin
          innum_d = 1'b1;
          seen_d = 1'b0;
          mant_d = {60'b0, dig};
          fcnt_d = '0;
        end else begin
          case (c)
            "x": begin main_v = 1'b1; main_t = mk_tok(K_NUM, P_NUM, x_q); end
            "p": if (a == "i") begin
              main_v = 1'b1; main_t = mk_tok(K_NUM, P_NUM, PI_VALUE); skip_d = 2'd1;
            end
            "+", "-": begin
              if (!(any_q || pre_v) || prev_q == "(") begin
                pre_v = 1'b1; pre_t = mk_tok(K_NUM, P_NUM, '0);
              end
              main_v = 1'b1;
              main_t = mk_tok((c == "+") ? K_PLUS : K_MINUS, P_ADD, '0);
            end
            "*": begin main_v = 1'b1; main_t = mk_tok(K_MUL, P_MUL, '0); end
            "/": begin main_v = 1'b1; main_t = mk_tok(K_DIV, P_MUL, '0); end
            "^": begin main_v = 1'b1; main_t = mk_tok(K_POW, P_POW, '0); end
            "%": begin main_v = 1'b1; main_t = mk_tok(K_MOD, P_MUL, '0); end
            "c": if (a == "o" && b == "s") begin
              main_v = 1'b1; main_t = mk_tok(K_COS, P_FUNC, '0); skip_d = 2'd2;
            end
            "s": begin
              if (a == "i" && b == "n") begin
                main_v = 1'b1; main_t = mk_tok(K_SIN, P_FUNC, '0); skip_d = 2'd2;
              end else if (a == "q" && b == "r" && d == "t") begin
                main_v = 1'b1; main_t = mk_tok(K_SQRT, P_POW, '0); skip_d = 2'd3;
              end
            end
            "t": if (a == "a" && b == "n") begin
              main_v = 1'b1; main_t = mk_tok(K_TAN, P_FUNC, '0); skip_d = 2'd2;
            end
            "a": begin
              if (a == "s" && b == "i" && d == "n") begin
                main_v = 1'b1; main_t = mk_tok(K_ASIN, P_FUNC, '0); skip_d = 2'd3;
              end else if (a == "c" && b == "o" && d == "s") begin
                main_v = 1'b1; main_t = mk_tok(K_ACOS, P_FUNC, '0); skip_d = 2'd3;
              end else if (a == "t" && b == "a" && d == "n") begin
                main_v = 1'b1; main_t = mk_tok(K_ATAN, P_FUNC, '0); skip_d = 2'd3;
              end
            end
            "l": begin
              if (a == "n") begin
                main_v = 1'b1; main_t = mk_tok(K_LN, P_FUNC, '0); skip_d = 2'd1;
              end else if (a == "o" && b == "g") begin
                main_v = 1'b1; main_t = mk_tok(K_LOG, P_FUNC, '0); skip_d = 2'd2;
              end
            end
            "(": begin main_v = 1'b1; main_t = mk_tok(K_OPEN, P_BRKT, '0); end
            ")": begin main_v = 1'b1; main_t = mk_tok(K_CLOSE, P_BRKT, '0); end
            default: ;
          endcase
        end
      end
    end else if (st_q == FR_FINAL && go && innum_q) begin
      pre_v = 1'b1;
      pre_t = mk_raw(mant_q, fcnt_q);
      innum_d = 1'b0;
    end
    any_d = any_q || pre_v || main_v;
  end

  // compact new tokens, route through the hold slot while flushing
  always_comb begin
    nn = 2'(pre_v) + 2'(main_v);
    n0 = pre_v ? pre_t : main_t;
    n1 = main_t;
    push_o = '0;
    hold_d = hold_q;
    hv_d = hv_q;
    case (st_q)
      FR_RUN: begin
        push_o.n = nn;
        push_o.t0 = n0;
        push_o.t1 = n1;
      end
      FR_FLUSH, FR_FINAL: begin
        if (hv_q && nn != 2'd0) begin
          push_o.t0 = hold_q;
          push_o.t1 = n0;
          push_o.n = nn;
          hold_d = (nn == 2'd2) ? n1 : n0;
        end else if (!hv_q && nn != 2'd0) begin
          push_o.t0 = n0;
          push_o.n = nn - 2'd1;
          hold_d = (nn == 2'd2) ? n1 : n0;
          hv_d = 1'b1;
        end
      end
      FR_DONE: begin
        if (go) begin
          push_o.t0 = hold_q;
          push_o.t0.eor = 1'b1;
          push_o.n = {1'b0, hv_q};
          hv_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // lookahead window
  always_comb begin
    w_d = w_q;
    n_d = n_q;
    if (acc) begin
      if (!char_i.last && n_q == 3'd3) begin
        w_d[0] = w_q[1];
        w_d[1] = w_q[2];
        w_d[2] = char_i.ch;
      end else begin
        w_d[n_q[1:0]] = char_i.ch;
        n_d = n_q + 3'd1;
      end
    end else if (st_q == FR_FLUSH && go) begin
      w_d[0] = w_q[1];
      w_d[1] = w_q[2];
      w_d[2] = w_q[3];
      w_d[3] = '0;
      n_d = n_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FR_RUN;
      for (int i = 0; i < 4; i++) w_q[i] <= '0;
      n_q <= '0;
      prev_q <= '0;
      any_q <= 1'b0;
      innum_q <= 1'b0;
      seen_q <= 1'b0;
      mant_q <= '0;
      fcnt_q <= '0;
      skip_q <= '0;
      hv_q <= 1'b0;
    end else if (st_q == FR_DONE && go) begin
      st_q <= st_d;
      for (int i = 0; i < 4; i++) w_q[i] <= '0;
      n_q <= '0;
      prev_q <= '0;
      any_q <= 1'b0;
      innum_q <= 1'b0;
      seen_q <= 1'b0;
      mant_q <= '0;
      fcnt_q <= '0;
      skip_q <= '0;
      hv_q <= hv_d;
    end else begin
      st_q <= st_d;
      w_q <= w_d;
      n_q <= n_d;
      prev_q <= prev_d;
      any_q <= any_d;
      innum_q <= innum_d;
      seen_q <= seen_d;
      mant_q <= mant_d;
      fcnt_q <= fcnt_d;
      skip_q <= skip_d;
      hv_q <= hv_d;
    end
  end

  always_ff @(posedge clk_i) hold_q <= hold_d;

endmodule

// ===== hw/rtl/etok_queue.sv =====
// ---------------------------------------------------------------------------
// Tokenizer token queue
// Eight-entry FIFO, up to two writes and one read per cycle.
// ---------------------------------------------------------------------------
module etok_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  etok_pkg::push_t  push_i,
  input  logic             pop_i,
  output logic             valid_o,
  output etok_pkg::tok_t   head_o,
  output logic [3:0]       free_o
);
  import etok_pkg::*;

  tok_t           mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QCW-1:0] cnt_q;

  assign valid_o = cnt_q != '0;
  assign head_o = mem_q[rp_q];
  assign free_o = QCW'(QDEPTH) - cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wp_q] <= push_i.t0;
    if (push_i.n == 2'd2) mem_q[wp_q + QAW'(1)] <= push_i.t1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      wp_q <= wp_q + QAW'(push_i.n);
      rp_q <= rp_q + QAW'(pop_i);
      cnt_q <= cnt_q + QCW'(push_i.n) - QCW'(pop_i);
    end
  end

endmodule

// ===== hw/rtl/etok_back.sv =====
// ---------------------------------------------------------------------------
// Tokenizer back end
// Decimal to fixed-point conversion by restoring division; output register.
// ---------------------------------------------------------------------------
module etok_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  etok_pkg::tok_t  head_i,
  output logic            pop_o,
  etok_tok_if.source      tok_o
);
  import etok_pkg::*;

  bk_state_e         st_q, st_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic [63:0]       rem_q, rem_d, p_q;
  logic [DCW-1:0]    cnt_q;
  logic              deor_q;
  logic              ov_q;
  tok_t              o_q, o_d;

  logic              out_free, is_div, start, load;
  logic [64:0]       t;
  logic              ge;
  logic [63:0]       fast_val, div_val;

  assign out_free = !ov_q || tok_o.ready;
  assign is_div = head_i.raw && head_i.fcnt != '0;
  assign fast_val = (|head_i.value[63:63-FRAC_BITS]) ? 64'h7FFFFFFFFFFFFFFF
                    : (head_i.value << FRAC_BITS);
  assign div_val = (|quo_q[DIV_STEPS-1:63]) ? 64'h7FFFFFFFFFFFFFFF : quo_q[63:0];

  // one quotient bit per cycle
  assign t = {rem_q, quo_q[DIV_STEPS-1]};
  assign ge = t >= {1'b0, p_q};
  assign rem_d = ge ? 64'(t - {1'b0, p_q}) : t[63:0];
  assign quo_d = {quo_q[DIV_STEPS-2:0], ge};

  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: if (valid_i && is_div) st_d = BK_DIV;
      BK_DIV:  if (cnt_q == '0 && out_free) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o = 1'b0;
    start = 1'b0;
    load = 1'b0;
    o_d = o_q;
    case (st_q)
      BK_IDLE: begin
        if (valid_i && is_div) begin
          pop_o = 1'b1;
          start = 1'b1;
        end else if (valid_i && out_free) begin
          pop_o = 1'b1;
          load = 1'b1;
          o_d = head_i;
          if (head_i.raw) o_d.value = fast_val;
        end
      end
      BK_DIV: begin
        if (cnt_q == '0 && out_free) begin
          load = 1'b1;
          o_d = mk_tok(K_NUM, P_NUM, div_val);
          o_d.eor = deor_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      quo_q <= {head_i.value, FRAC_BITS'(0)};
      rem_q <= '0;
      p_q <= pow10(head_i.fcnt);
      deor_q <= head_i.eor;
    end else if (st_q == BK_DIV && cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (load) o_q <= o_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (start) cnt_q <= DCW'(DIV_STEPS);
      else if (st_q == BK_DIV && cnt_q != '0) cnt_q <= cnt_q - DCW'(1);
      if (load) ov_q <= 1'b1;
      else if (tok_o.ready) ov_q <= 1'b0;
    end
  end

  assign tok_o.valid = ov_q;
  assign tok_o.kind = o_q.kind;
  assign tok_o.priority_res = o_q.prio;
  assign tok_o.value = o_q.value;
  assign tok_o.end_of_run = o_q.eor;

endmodule
